### hdl/mdrp_pkg.sv
// Package with the codes and types shared by the duty ramp profile block.
`timescale 1ns / 1ps
package mdrp_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  // Test modes carried by a start beat.
  localparam logic [1:0] MODE_SHORT    = 2'd0;
  localparam logic [1:0] MODE_LONG     = 2'd1;
  localparam logic [1:0] MODE_THROTTLE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLOOR   = 2'd0;
  localparam logic [1:0] CFG_CEILING = 2'd1;
  localparam logic [1:0] CFG_HOLD    = 2'd2;

  localparam int unsigned LEN_BITS   = 10;
  localparam int unsigned TICK_BITS  = 16;
  localparam int unsigned FIELD_BITS = 16;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_HOLD = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### hdl/motor_duty_ramp_profile_top.sv
// Motor duty ramp profile generator with a shared serial divider for the ramp step.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  item     | item_valid, item_stall, kind .. duty_value        | in
//  result   | result_valid, result_stall, duty_out .. finished  | out
//  config   | cfg_write, cfg_index, cfg_data                    | in
//
// A tick or set-duty beat is latched at acceptance, runs the execute state and
// loads its result in the done state; the next beat is taken in the cycle after.
// A start beat, and a tick that enters the fall, with a length of 2 or more also
// pass the divider state: the restoring divider retires one quotient bit a cycle.
// Reset (rst, synchronous) empties the result register and clears the profile.
// A new item is taken once the previous result is loaded; result_stall only
// holds a finished result and delays the load of the next one.
`timescale 1ns / 1ps
module motor_duty_ramp_profile_top #(
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          kind,
  input  logic [1:0]                          test_mode,
  input  logic [mdrp_pkg::LEN_BITS-1:0]       rise_ticks,
  input  logic [11:0]                         stay_ticks,
  input  logic [mdrp_pkg::LEN_BITS-1:0]       fall_ticks,
  input  logic [mdrp_pkg::FIELD_BITS-1:0]     duty_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mdrp_pkg::FIELD_BITS-1:0]     duty_out,
  output logic [1:0]                          phase,
  output logic                                accepted,
  output logic                                finished,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [mdrp_pkg::FIELD_BITS-1:0]     cfg_data
);
  import mdrp_pkg::*;

  // Duty values never exceed the 16-bit register fields.
  localparam int unsigned DW = (DUTY_BITS < FIELD_BITS) ? DUTY_BITS : FIELD_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  // Configuration.
  logic [DW-1:0]        cfg_floor;
  logic [DW-1:0]        cfg_ceiling;
  logic [TICK_BITS-1:0] cfg_hold;

  // Profile state.
  phase_t               phase_reg;
  logic [DW-1:0]        duty_level;
  logic [DW-1:0]        step_size;
  logic [TICK_BITS-1:0] ticks_left;
  logic [LEN_BITS-1:0]  held_fall_len;
  logic [TICK_BITS-1:0] held_hold_len;

  // Latched item.
  logic [1:0]           it_kind;
  logic [1:0]           it_mode;
  logic [LEN_BITS-1:0]  it_rise;
  logic [11:0]          it_stay;
  logic [LEN_BITS-1:0]  it_fall;
  logic [DW-1:0]        it_dval;

  // Result waiting for the output register.
  logic                 res_acc;
  logic                 res_fin;

  // Serial divider.
  logic [LEN_BITS-1:0]  div_rem;
  logic [DW-1:0]        div_quo;
  logic [LEN_BITS-1:0]  div_den;
  logic [CW-1:0]        div_cnt;
  logic [LEN_BITS:0]    div_trial;
  logic                 div_ge;
  logic [LEN_BITS:0]    div_diff;
  logic [DW-1:0]        div_quo_next;
  logic [LEN_BITS-1:0]  div_rem_next;

  state_t state, state_next;

  // Execute-step values.
  logic [DW-1:0]        span;
  phase_t               phase_next;
  logic [DW-1:0]        duty_next;
  logic [TICK_BITS-1:0] ticks_next;
  logic [TICK_BITS-1:0] ticks_dec;
  logic [LEN_BITS-1:0]  fall_len_next;
  logic [TICK_BITS-1:0] hold_len_next;
  logic                 acc_next;
  logic                 fin_next;
  logic                 div_go;
  logic [LEN_BITS-1:0]  div_len;
  logic [DW:0]          rise_sum;
  logic [DW:0]          fall_lim;
  logic [DW-1:0]        dval_hi;
  logic                 result_load;

  always_comb begin
    span = (cfg_ceiling > cfg_floor) ? (cfg_ceiling - cfg_floor) : '0;
    ticks_dec = (ticks_left != '0) ? (ticks_left - 1'b1) : ticks_left;
    rise_sum = {1'b0, duty_level} + {1'b0, step_size};
    fall_lim = {1'b0, cfg_floor} + {1'b0, step_size};
    dval_hi = (it_dval > cfg_ceiling) ? cfg_ceiling : it_dval;
  end

  // Divider iteration: one quotient bit per cycle.
  always_comb begin
    div_trial = {div_rem, div_quo[DW-1]};
    div_diff = div_trial - {1'b0, div_den};
    div_ge = (div_trial >= {1'b0, div_den});
    div_rem_next = div_ge ? div_diff[LEN_BITS-1:0] : div_trial[LEN_BITS-1:0];
    div_quo_next = {div_quo[DW-2:0], div_ge};
  end

  // Execute step: everything but the division of a new ramp step.
  always_comb begin
    phase_next = phase_reg;
    duty_next = duty_level;
    ticks_next = ticks_left;
    fall_len_next = held_fall_len;
    hold_len_next = held_hold_len;
    acc_next = 1'b0;
    fin_next = 1'b0;
    div_go = 1'b0;
    div_len = '0;
    unique case (it_kind)
      KIND_START: begin
        if (phase_reg == PH_IDLE && it_mode <= MODE_THROTTLE) begin
          acc_next = 1'b1;
          duty_next = cfg_floor;
          ticks_next = TICK_BITS'(it_rise) + 1'b1;
          fall_len_next = it_fall;
          case (it_mode)
            MODE_SHORT: hold_len_next = TICK_BITS'(it_stay);
            MODE_LONG:  hold_len_next = cfg_hold;
            default:    hold_len_next = '0;
          endcase
          phase_next = PH_RISE;
          div_go = 1'b1;
          div_len = it_rise;
        end
      end
      KIND_SET: begin
        duty_next = (dval_hi < cfg_floor) ? cfg_floor : dval_hi;
      end
      KIND_TICK: begin
        case (phase_reg)
          PH_RISE: begin
            duty_next = (rise_sum > {1'b0, cfg_ceiling}) ? cfg_ceiling : rise_sum[DW-1:0];
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
              if (held_hold_len != '0) begin
                ticks_next = held_hold_len;
                phase_next = PH_HOLD;
              end else begin
                ticks_next = TICK_BITS'(held_fall_len) + 1'b1;
                phase_next = PH_FALL;
                div_go = 1'b1;
                div_len = held_fall_len;
              end
            end
          end
          PH_HOLD: begin
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
              ticks_next = TICK_BITS'(held_fall_len) + 1'b1;
              phase_next = PH_FALL;
              div_go = 1'b1;
              div_len = held_fall_len;
            end
          end
          PH_FALL: begin
            duty_next = ({1'b0, duty_level} < fall_lim) ? cfg_floor : (duty_level - step_size);
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
              phase_next = PH_IDLE;
              fin_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (item_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = (div_go && div_len > LEN_BITS'(1)) ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_cnt == CW'(1)) state_next = ST_DONE;
      ST_DONE: if (!result_valid || !result_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    item_stall = (state != ST_IDLE);
    result_load = (state == ST_DONE) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
      cfg_floor <= '0;
      cfg_ceiling <= DW'(16'hFFFF);
      cfg_hold <= TICK_BITS'(60);
      phase_reg <= PH_IDLE;
      duty_level <= '0;
      step_size <= '0;
      ticks_left <= '0;
      held_fall_len <= '0;
      held_hold_len <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_FLOOR:   cfg_floor <= cfg_data[DW-1:0];
          CFG_CEILING: cfg_ceiling <= cfg_data[DW-1:0];
          CFG_HOLD:    cfg_hold <= cfg_data;
          default: begin
          end
        endcase
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == ST_EXEC) begin
        phase_reg <= phase_next;
        duty_level <= duty_next;
        ticks_left <= ticks_next;
        held_fall_len <= fall_len_next;
        held_hold_len <= hold_len_next;
        // A length of 0 or 1 takes the whole span as the step.
        if (div_go && div_len <= LEN_BITS'(1)) step_size <= span;
      end
      if (state == ST_DIV && div_cnt == CW'(1)) begin
        step_size <= div_quo_next;
      end
    end
  end

  // Payload and datapath registers without reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      it_kind <= kind;
      it_mode <= test_mode;
      it_rise <= rise_ticks;
      it_stay <= stay_ticks;
      it_fall <= fall_ticks;
      it_dval <= duty_value[DW-1:0];
    end
    if (state == ST_EXEC) begin
      res_acc <= acc_next;
      res_fin <= fin_next;
      div_rem <= '0;
      div_quo <= span;
      div_den <= div_len - 1'b1;
      div_cnt <= CW'(DW);
    end else if (state == ST_DIV) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
      div_cnt <= div_cnt - 1'b1;
    end
    if (result_load) begin
      duty_out <= FIELD_BITS'(duty_level);
      phase <= phase_reg;
      accepted <= res_acc;
      finished <= res_fin;
    end
  end

  a_ticks_live: assert property (@(posedge clk) disable iff (rst)
    phase_reg != PH_IDLE |-> ticks_left != '0)
    else $error("active phase with no ticks left");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> phase == PH_IDLE)
    else $error("finished result without idle phase");

  a_accept_rise: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted |-> phase == PH_RISE && !finished)
    else $error("accepted start not reported as rising");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> state == ST_DIV || state == ST_DONE)
    else $error("divider left by a wrong path");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt != '0)
    else $error("divider running with an empty count");

endmodule

### test/testbench.sv
// Self-checking testbench for the motor duty ramp profile generator.
`timescale 1ns / 1ps
module testbench;
  import mdrp_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] MODE_BAD  = 2'd3;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 25;
  localparam int PER_PHASE      = 150;

  typedef struct packed {
    logic [15:0] duty;
    phase_t      ph;
    logic        acc;
    logic        fin;
  } duty_report_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [1:0]   mode;
    logic [9:0]   rise;
    logic [11:0]  stay;
    logic [9:0]   fall;
    logic [15:0]  dval;
    logic         pinned;
    duty_report_t want;
  } beat_t;

  typedef struct {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] hold;
    int          gap;
    int          stall;
    bit          long_ok;
    bit          squeeze;
  } setting_t;

  localparam duty_report_t NO_PIN = '{16'd0, PH_IDLE, 1'b0, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  kind = '0;
  logic [1:0]  test_mode = '0;
  logic [9:0]  rise_ticks = '0;
  logic [11:0] stay_ticks = '0;
  logic [9:0]  fall_ticks = '0;
  logic [15:0] duty_value = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [15:0] duty_out;
  logic [1:0]  phase;
  logic        accepted;
  logic        finished;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Pinned expectation that travels with the beat on offer.
  logic         pin_use = 1'b0;
  duty_report_t pin_want = NO_PIN;

  // Shadow of the configuration and the profile state.
  logic [15:0] floor_cfg = 16'd0;
  logic [15:0] ceiling_cfg = 16'hFFFF;
  logic [15:0] hold_cfg = 16'd60;
  phase_t      prof_phase = PH_IDLE;
  logic [15:0] prof_duty = '0;
  logic [15:0] prof_step = '0;
  logic [15:0] prof_ticks = '0;
  logic [9:0]  prof_fall_len = '0;
  logic [15:0] prof_hold_len = '0;

  duty_report_t duty_results_due[$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  squeeze_armed = 1'b0;
  bit  item_beat = 1'b0;

  beat_t plan [25] = '{
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_NONE, MODE_BAD, 10'h3FF, 12'hFFF, 10'h3FF, 16'hFFFF, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_SET, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'hFFFF, 1'b1,
      '{16'hFFFF, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_SET, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_START, MODE_BAD, 10'h3FF, 12'hFFF, 10'h3FF, 16'd0, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_START, MODE_THROTTLE, 10'd0, 12'hFFF, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_RISE, 1'b1, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'hFFFF, PH_FALL, 1'b0, 1'b0}},
    '{KIND_START, MODE_SHORT, 10'h3FF, 12'hFFF, 10'h3FF, 16'd0, 1'b1,
      '{16'hFFFF, PH_FALL, 1'b0, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b1}},
    '{KIND_START, MODE_SHORT, 10'd1, 12'd1, 10'd1, 16'd0, 1'b1,
      '{16'd0, PH_RISE, 1'b1, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'hFFFF, PH_RISE, 1'b0, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'hFFFF, PH_HOLD, 1'b0, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'hFFFF, PH_FALL, 1'b0, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_FALL, 1'b0, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b1,
      '{16'd0, PH_IDLE, 1'b0, 1'b1}},
    '{KIND_START, MODE_SHORT, 10'd2, 12'd0, 10'd2, 16'd0, 1'b1,
      '{16'd0, PH_RISE, 1'b1, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN},
    '{KIND_SET, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'h5A5A, 1'b1,
      '{16'h5A5A, PH_IDLE, 1'b0, 1'b0}},
    '{KIND_START, MODE_LONG, 10'd4, 12'd0, 10'd3, 16'd0, 1'b1,
      '{16'd0, PH_RISE, 1'b1, 1'b0}},
    '{KIND_TICK, MODE_SHORT, 10'd0, 12'd0, 10'd0, 16'd0, 1'b0, NO_PIN}
  };

  // Phases of the random part: limits, long hold, and how both sides idle.
  setting_t setting [5] = '{
    '{16'd0,     16'hFFFF,  16'd3,     0,  0,  1'b1, 1'b0},
    '{16'd1000,  16'd60000, 16'd0,     58, 0,  1'b1, 1'b0},
    '{16'hFFFF,  16'd0,     16'd5,     0,  58, 1'b1, 1'b0},
    '{16'd12345, 16'd54321, 16'hFFFF,  24, 24, 1'b0, 1'b0},
    '{16'd32768, 16'd32769, 16'd2,     0,  0,  1'b1, 1'b1}
  };

  motor_duty_ramp_profile_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .test_mode(test_mode),
    .rise_ticks(rise_ticks),
    .stay_ticks(stay_ticks),
    .fall_ticks(fall_ticks),
    .duty_value(duty_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .duty_out(duty_out),
    .phase(phase),
    .accepted(accepted),
    .finished(finished),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A length of 0 or 1 takes the whole span in one step.
  function automatic logic [15:0] ramp_step(input logic [15:0] len);
    logic [15:0] span;
    span = (ceiling_cfg > floor_cfg) ? ceiling_cfg - floor_cfg : 16'd0;
    if (len <= 16'd1) return span;
    return span / (len - 16'd1);
  endfunction

  function automatic void enter_fall();
    prof_step  = ramp_step({6'd0, prof_fall_len});
    prof_ticks = {6'd0, prof_fall_len} + 16'd1;
    prof_phase = PH_FALL;
  endfunction

  function automatic duty_report_t advance_profile(input beat_t b);
    duty_report_t r;
    logic [16:0]  sum;
    r.acc = 1'b0;
    r.fin = 1'b0;
    case (b.kind)
      KIND_START: begin
        if (prof_phase == PH_IDLE && b.mode != MODE_BAD) begin
          r.acc = 1'b1;
          prof_duty     = floor_cfg;
          prof_step     = ramp_step({6'd0, b.rise});
          prof_ticks    = {6'd0, b.rise} + 16'd1;
          prof_fall_len = b.fall;
          case (b.mode)
            MODE_SHORT: prof_hold_len = {4'd0, b.stay};
            MODE_LONG:  prof_hold_len = hold_cfg;
            default:    prof_hold_len = '0;
          endcase
          prof_phase = PH_RISE;
        end
      end
      KIND_SET: begin
        prof_duty = b.dval;
        if (prof_duty > ceiling_cfg) prof_duty = ceiling_cfg;
        if (prof_duty < floor_cfg) prof_duty = floor_cfg;
      end
      KIND_TICK: begin
        case (prof_phase)
          PH_RISE: begin
            sum = {1'b0, prof_duty} + {1'b0, prof_step};
            prof_duty = (sum > {1'b0, ceiling_cfg}) ? ceiling_cfg : sum[15:0];
            if (prof_ticks != 16'd0) prof_ticks = prof_ticks - 16'd1;
            if (prof_ticks == 16'd0) begin
              if (prof_hold_len != 16'd0) begin
                prof_ticks = prof_hold_len;
                prof_phase = PH_HOLD;
              end else begin
                enter_fall();
              end
            end
          end
          PH_HOLD: begin
            if (prof_ticks != 16'd0) prof_ticks = prof_ticks - 16'd1;
            if (prof_ticks == 16'd0) enter_fall();
          end
          PH_FALL: begin
            if ({1'b0, prof_duty} < {1'b0, floor_cfg} + {1'b0, prof_step})
              prof_duty = floor_cfg;
            else
              prof_duty = prof_duty - prof_step;
            if (prof_ticks != 16'd0) prof_ticks = prof_ticks - 16'd1;
            if (prof_ticks == 16'd0) begin
              prof_phase = PH_IDLE;
              r.fin = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.duty = prof_duty;
    r.ph   = prof_phase;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Scoreboard: results are compared at the edge that accepts them, and every
  // accepted item beat runs through the shadow profile.
  always @(posedge clk) begin : watch
    duty_report_t want;
    duty_report_t calc;
    beat_t        b;
    item_beat = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (duty_results_due.size() == 0) begin
          $display("%0t: unexpected result, duty %0d phase %0d accepted %0b finished %0b",
                   $time, duty_out, phase, accepted, finished);
          fail_count++;
        end else begin
          want = duty_results_due.pop_front();
          check_field("duty_out", want.duty, duty_out);
          check_field("phase", want.ph, phase);
          check_field("accepted", want.acc, accepted);
          check_field("finished", want.fin, finished);
        end
      end
      if (item_valid && !item_stall) begin
        item_beat = 1'b1;
        b = '{kind, test_mode, rise_ticks, stay_ticks, fall_ticks, duty_value, 1'b0, NO_PIN};
        calc = advance_profile(b);
        duty_results_due.push_back(pin_use ? pin_want : calc);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver side; an armed squeeze holds the result off long enough for the
  // block to fill up and stall its input.
  initial begin
    forever begin
      @(negedge clk);
      if (squeeze_armed) begin
        squeeze_armed <= 1'b0;
        result_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic offer(input beat_t b);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= b.kind;
    test_mode  <= b.mode;
    rise_ticks <= b.rise;
    stay_ticks <= b.stay;
    fall_ticks <= b.fall;
    duty_value <= b.dval;
    pin_use    <= b.pinned;
    pin_want   <= b.want;
    do @(negedge clk); while (!item_beat);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FLOOR:   floor_cfg = val;
      CFG_CEILING: ceiling_cfg = val;
      default:     hold_cfg = val;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly short ramps, now and then a long one.
  function automatic logic [9:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 1) return 10'($urandom_range(0, 1023));
    if (roll < 12) return 10'($urandom_range(0, 40));
    return 10'($urandom_range(0, 6));
  endfunction

  // Starts while idle and ticks while running dominate; the rest is noise.
  task automatic pick_beat(input bit long_ok, output beat_t b);
    int roll;
    roll     = $urandom_range(0, 99);
    b.kind   = KIND_TICK;
    b.mode   = 2'($urandom);
    b.rise   = 10'($urandom);
    b.stay   = 12'($urandom);
    b.fall   = 10'($urandom);
    b.dval   = 16'($urandom);
    b.pinned = 1'b0;
    b.want   = NO_PIN;
    if (prof_phase == PH_IDLE) begin
      if (roll < 72) begin
        b.kind = KIND_START;
        if (long_ok)
          b.mode = 2'($urandom_range(0, 2));
        else
          b.mode = $urandom_range(0, 1) ? MODE_THROTTLE : MODE_SHORT;
        b.rise = pick_len();
        b.fall = pick_len();
        b.stay = ($urandom_range(0, 99) < 2) ? 12'($urandom_range(0, 200))
                                              : 12'($urandom_range(0, 8));
      end else if (roll < 80) begin
        b.kind = KIND_START;
        b.mode = MODE_BAD;
      end else if (roll < 88) begin
        b.kind = KIND_SET;
      end else if (roll < 94) begin
        b.kind = KIND_NONE;
      end
    end else begin
      if (roll >= 96) b.kind = KIND_NONE;
      else if (roll >= 91) b.kind = KIND_START;
      else if (roll >= 84) b.kind = KIND_SET;
    end
    if (b.kind == KIND_SET) begin
      case ($urandom_range(0, 3))
        0:       b.dval = 16'd0;
        1:       b.dval = 16'hFFFF;
        default: ;
      endcase
    end
  endtask

  initial begin : stimulus
    int    counted;
    beat_t b;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) offer(plan[i]);
    foreach (setting[p]) begin
      item_valid <= 1'b0;
      while (duty_results_due.size() != 0) @(negedge clk);
      write_reg(CFG_FLOOR, setting[p].lo);
      write_reg(CFG_CEILING, setting[p].hi);
      write_reg(CFG_HOLD, setting[p].hold);
      gap_pct = setting[p].gap;
      stall_pct <= setting[p].stall;
      squeeze_armed <= setting[p].squeeze;
      counted = 0;
      while (counted < PER_PHASE) begin
        pick_beat(setting[p].long_ok, b);
        // Only beats that change the profile count toward the phase.
        if (b.kind == KIND_SET || (b.kind == KIND_TICK && prof_phase != PH_IDLE) ||
            (b.kind == KIND_START && prof_phase == PH_IDLE && b.mode != MODE_BAD))
          counted++;
        offer(b);
      end
    end
    item_valid <= 1'b0;
    while (duty_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hdl/mdrp_pkg.sv
hdl/motor_duty_ramp_profile_top.sv
test/testbench.sv
